@@ rtl/tempo_row_rate_accumulator_core_macros.svh @@
// Assertion macros shared by the accumulator core files.
`ifndef TEMPO_ROW_RATE_ACCUMULATOR_CORE_MACROS_SVH
`define TEMPO_ROW_RATE_ACCUMULATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge out of reset.
`define TRAC_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("trac: property violated");
// Condition must never be true out of reset.
`define TRAC_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("trac: forbidden condition seen");
`else
`define TRAC_ASSERT(label, clk, rstn, prop)
`define TRAC_ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

@@ rtl/trac_pkg.sv @@
package trac_pkg;

  // Field and datapath widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned SCALED_W    = 13;
  localparam int unsigned REFILL_W    = 14;
  localparam int unsigned OUT_ACC_W   = 14;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned DIV_CNT_W   = $clog2(SCALED_W);

  // Default accumulator width
  localparam int unsigned ACCUM_BITS_DEF = 14;

  // Arithmetic constants
  localparam logic [4:0] TEMPO_MUL  = 5'd24;
  localparam logic [5:0] REFILL_MUL = 6'd60;

  // Reset values
  localparam logic [BYTE_W-1:0]   FRAME_RATE_RST = 8'd60;
  localparam logic [BYTE_W-1:0]   SPLIT_RST      = 8'd32;
  localparam logic [BYTE_W-1:0]   TEMPO_RST      = 8'd150;
  localparam logic [BYTE_W-1:0]   SPEED_RST      = 8'd6;
  localparam logic [SCALED_W-1:0] DEC_RST        = 13'd600;

  // Request kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_EFFECT = 2'd1,
    FUNC_LOAD   = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_RATE = 1'b0,
    CFG_SPLIT      = 1'b1
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUT
  } state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/trac_div.sv @@
`include "tempo_row_rate_accumulator_core_macros.svh"

module trac_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [trac_pkg::SCALED_W-1:0]  dividend_i,
  input  logic [trac_pkg::BYTE_W-1:0]    divisor_i,
  output logic [trac_pkg::SCALED_W-1:0]  quot_o,
  output logic [trac_pkg::BYTE_W-1:0]    rem_o,
  output trac_pkg::div_stat_t            stat_o
);
  import trac_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(SCALED_W - 1);

  logic [SCALED_W-1:0]  quo_q, quo_d;
  logic [BYTE_W-1:0]    rem_q, rem_d;
  logic [BYTE_W-1:0]    dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [BYTE_W:0]      trial;
  logic [BYTE_W:0]      diff;
  logic                 qbit;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial = {rem_q, quo_q[SCALED_W-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
  end

  // Advance the iteration
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[SCALED_W-2:0], qbit};
      rem_d = qbit ? diff[BYTE_W-1:0] : trial[BYTE_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quot_o      = quo_q;
  assign rem_o       = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `TRAC_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `TRAC_ASSERT_NEVER(a_no_start_busy, clk_i, rst_ni, start_i && busy_q)
  `TRAC_ASSERT(a_cnt_bound, clk_i, rst_ni, busy_q |-> cnt_q <= LAST)

endmodule

@@ rtl/tempo_row_rate_accumulator_core.sv @@
// Tick request: the accumulator updates on accept; the PUT state then loads the output register once it is free.
// Effect or load request with nonzero tempo: the 13-step shared restoring divider runs in the
// DIV state, then PUT hands the result over. No new request is taken until the block is back in idle.
// Tempo zero or unused kind: no division; the block goes straight to the PUT state, then back to idle.
// Asynchronous active-low reset: tempo 150, speed 6, decrement 600, accumulator and
// remainder zero, frame rate 60, split point 32, output empty.
`include "tempo_row_rate_accumulator_core_macros.svh"

module tempo_row_rate_accumulator_core #(
  parameter int unsigned ACCUM_BITS = trac_pkg::ACCUM_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration writes
  input  logic                             cfg_we_i,
  input  trac_pkg::cfg_idx_e               cfg_idx_i,
  input  logic [trac_pkg::BYTE_W-1:0]      cfg_wdata_i,
  // Request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: param[7:0], load_tempo[15:8], load_speed[23:16]
  input  logic [trac_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: func[1:0]
  input  logic [trac_pkg::FUNC_W-1:0]      s_axis_tuser,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: row_ready[0], accum_value[14:1], zero pad[15]
  output logic [trac_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import trac_pkg::*;

  localparam int unsigned SUM_W = ACCUM_BITS + 2;
  localparam logic signed [SUM_W-1:0] ACC_HI = {3'b000, {(ACCUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_LO = {3'b111, {(ACCUM_BITS-1){1'b0}}};

  // Configuration registers
  logic [BYTE_W-1:0] frame_rate_q;
  logic [BYTE_W-1:0] split_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rate_q <= FRAME_RATE_RST;
      split_q      <= SPLIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_RATE: frame_rate_q <= cfg_wdata_i;
        CFG_SPLIT:      split_q      <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  state_e                  state_q, state_d;
  logic [BYTE_W-1:0]       tempo_q, tempo_d;
  logic [BYTE_W-1:0]       speed_q, speed_d;
  logic [ACCUM_BITS-1:0]   acc_q, acc_d;
  logic [SCALED_W-1:0]     dec_q, dec_d;
  logic [BYTE_W-1:0]       rem_q, rem_d;
  logic                    out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]   out_data_q, out_data_d;

  logic [BYTE_W-1:0]       req_param;
  logic [BYTE_W-1:0]       req_tempo;
  logic [BYTE_W-1:0]       req_speed;
  logic                    req_take;
  logic [BYTE_W-1:0]       param_speed;
  logic [BYTE_W-1:0]       load_speed_c;
  logic [BYTE_W-1:0]       new_tempo;
  logic [BYTE_W-1:0]       new_speed;
  logic [SCALED_W-1:0]     scaled;
  logic [REFILL_W-1:0]     refill;
  logic                    acc_le_zero;
  logic signed [SUM_W-1:0] acc_ext;
  logic signed [SUM_W-1:0] add_ext;
  logic signed [SUM_W-1:0] sum;
  logic [ACCUM_BITS-1:0]   acc_sat;
  logic                    div_start;
  logic [SCALED_W-1:0]     div_quot;
  logic [BYTE_W-1:0]       div_rem;
  div_stat_t               div_stat;

  assign req_param = s_axis_tdata[BYTE_W-1:0];
  assign req_tempo = s_axis_tdata[2*BYTE_W-1:BYTE_W];
  assign req_speed = s_axis_tdata[3*BYTE_W-1:2*BYTE_W];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign req_take  = s_axis_tvalid && s_axis_tready;

  // Clamp speeds to at least one
  assign param_speed  = (req_param == '0) ? BYTE_W'(1) : req_param;
  assign load_speed_c = (req_speed == '0) ? BYTE_W'(1) : req_speed;

  // Tempo scaled for the divider
  assign scaled = SCALED_W'(new_tempo) * SCALED_W'(TEMPO_MUL);

  // Tick arithmetic: optional refill less remainder, then decrement, saturate once
  assign acc_le_zero = acc_q[ACCUM_BITS-1] || (acc_q == '0);
  assign refill  = (tempo_q != '0)
                 ? REFILL_W'(frame_rate_q) * REFILL_W'(REFILL_MUL)
                 : REFILL_W'(speed_q);
  assign acc_ext = {{2{acc_q[ACCUM_BITS-1]}}, acc_q};
  assign add_ext = acc_le_zero
                 ? $signed(SUM_W'(refill)) - $signed(SUM_W'(rem_q))
                 : '0;
  assign sum     = acc_ext + add_ext - $signed(SUM_W'(dec_q));

  always_comb begin
    if (sum > ACC_HI) begin
      acc_sat = ACC_HI[ACCUM_BITS-1:0];
    end else if (sum < ACC_LO) begin
      acc_sat = ACC_LO[ACCUM_BITS-1:0];
    end else begin
      acc_sat = sum[ACCUM_BITS-1:0];
    end
  end

  // Sequencer: take a request, run the divider if needed, hand the result over
  always_comb begin
    state_d     = state_q;
    tempo_d     = tempo_q;
    speed_d     = speed_q;
    acc_d       = acc_q;
    dec_d       = dec_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    div_start   = 1'b0;
    new_tempo   = tempo_q;
    new_speed   = speed_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          unique case (s_axis_tuser)
            FUNC_TICK: begin
              acc_d   = acc_sat;
              state_d = ST_PUT;
            end
            FUNC_EFFECT, FUNC_LOAD: begin
              if (s_axis_tuser == FUNC_LOAD) begin
                new_tempo = req_tempo;
                new_speed = load_speed_c;
                acc_d     = '0;
              end else if (tempo_q != '0 && req_param >= split_q) begin
                new_tempo = req_param;
              end else begin
                new_speed = param_speed;
              end
              tempo_d = new_tempo;
              speed_d = new_speed;
              if (new_tempo == '0) begin
                dec_d   = SCALED_W'(1);
                rem_d   = '0;
                state_d = ST_PUT;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
            default: state_d = ST_PUT;
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          dec_d   = div_quot;
          rem_d   = div_rem;
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, acc_q[OUT_ACC_W-1:0], acc_le_zero};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tempo_q     <= TEMPO_RST;
      speed_q     <= SPEED_RST;
      acc_q       <= '0;
      dec_q       <= DEC_RST;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tempo_q     <= tempo_d;
      speed_q     <= speed_d;
      acc_q       <= acc_d;
      dec_q       <= dec_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  trac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scaled),
    .divisor_i  (new_speed),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .stat_o     (div_stat)
  );

  `TRAC_ASSERT(a_done_in_div, clk_i, rst_ni, div_stat.done |-> state_q == ST_DIV)
  `TRAC_ASSERT_NEVER(a_speed_nonzero, clk_i, rst_ni, speed_q == '0)
  `TRAC_ASSERT(a_load_clears, clk_i, rst_ni, (req_take && s_axis_tuser == FUNC_LOAD) |=> acc_q == '0)

endmodule

@@ dv/tempo_row_timer_checker.sv @@
module tempo_row_timer_checker
  import trac_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_idx_e              cfg_idx_i,
  input  logic [BYTE_W-1:0]     cfg_wdata_i,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  // req_data_i: param[7:0], load_tempo[15:8], load_speed[23:16]
  input  logic [IN_DATA_W-1:0]  req_data_i,
  // req_kind_i: func[1:0]
  input  logic [FUNC_W-1:0]     req_kind_i,
  input  logic                  row_valid_i,
  input  logic                  row_ready_i,
  // row_data_i: row_ready[0], accum_value[14:1], zero pad[15]
  input  logic [OUT_DATA_W-1:0] row_data_i,
  output int                    mismatches_o,
  output int                    pending_o
);

  localparam int ACC_W            = ACCUM_BITS_DEF;
  localparam int ACC_MAX          = (1 << (ACC_W - 1)) - 1;
  localparam int ACC_MIN          = -ACC_MAX - 1;
  localparam int SECONDS_PER_MIN  = 60;
  localparam int TICKS_PER_BEAT   = 24;

  typedef struct packed {
    logic                 row_ready;
    logic [OUT_ACC_W-1:0] accum;
  } row_result_t;

  // Rows predicted but not yet seen on the result stream
  row_result_t row_expect_q[$];

  // Shadow of the timing state and the configuration
  int frame_rate_q;
  int split_q;
  int tempo_q;
  int speed_q;
  int step_q;
  int frac_q;
  int acc_q;

  // Rebuild per-tick decrement and its remainder from tempo and speed
  function automatic void refresh_step();
    int scaled;
    if (speed_q == 0) speed_q = 1;
    if (tempo_q != 0) begin
      scaled = tempo_q * TICKS_PER_BEAT;
      step_q = scaled / speed_q;
      frac_q = scaled % speed_q;
    end else begin
      step_q = 1;
      frac_q = 0;
    end
  endfunction

  // Apply one request to the shadow state and return the row it reports
  function automatic row_result_t advance_row_timer(logic [FUNC_W-1:0] kind,
                                                    logic [BYTE_W-1:0] param,
                                                    logic [BYTE_W-1:0] tempo,
                                                    logic [BYTE_W-1:0] speed);
    int          nxt;
    row_result_t res;
    case (kind)
      FUNC_TICK: begin
        nxt = acc_q;
        if (acc_q <= 0) begin
          if (tempo_q != 0) nxt += SECONDS_PER_MIN * frame_rate_q - frac_q;
          else nxt += speed_q - frac_q;
        end
        nxt -= step_q;
        if (nxt > ACC_MAX) acc_q = ACC_MAX;
        else if (nxt < ACC_MIN) acc_q = ACC_MIN;
        else acc_q = nxt;
      end
      FUNC_EFFECT: begin
        if (tempo_q != 0 && int'(param) >= split_q) tempo_q = int'(param);
        else speed_q = (param == '0) ? 1 : int'(param);
        refresh_step();
      end
      FUNC_LOAD: begin
        tempo_q = int'(tempo);
        speed_q = (speed == '0) ? 1 : int'(speed);
        acc_q   = 0;
        refresh_step();
      end
      default: ;  // unused kind leaves the state alone
    endcase
    res.row_ready = (acc_q <= 0);
    res.accum     = OUT_ACC_W'(acc_q);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    row_result_t want;
    if (!rst_ni) begin
      row_expect_q.delete();
      frame_rate_q = 60;
      split_q      = 32;
      tempo_q      = 150;
      speed_q      = 6;
      step_q       = 600;
      frac_q       = 0;
      acc_q        = 0;
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // Track configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_RATE: frame_rate_q = int'(cfg_wdata_i);
          CFG_SPLIT:      split_q = int'(cfg_wdata_i);
          default: ;
        endcase
      end
      // Compare each delivered row with the oldest prediction
      if (row_valid_i && row_ready_i) begin
        if (row_expect_q.size() == 0) begin
          $error("row result with no request pending: data %h", row_data_i);
          mismatches_o++;
        end else begin
          want = row_expect_q.pop_front();
          if (row_data_i[0] !== want.row_ready) begin
            $error("row_ready: expected %0d, actual %0d", want.row_ready, row_data_i[0]);
            mismatches_o++;
          end
          if (row_data_i[OUT_ACC_W:1] !== want.accum) begin
            $error("accum_value: expected %0d, actual %0d",
                   $signed(want.accum), $signed(row_data_i[OUT_ACC_W:1]));
            mismatches_o++;
          end
        end
      end
      // Predict the row for each accepted request
      if (req_valid_i && req_ready_i) begin
        row_expect_q.push_back(advance_row_timer(req_kind_i, req_data_i[7:0],
                                                 req_data_i[15:8], req_data_i[23:16]));
      end
      pending_o = row_expect_q.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  import trac_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [BYTE_W-1:0]     cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [FUNC_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    mismatches;
  int                    pending;

  // Sender pacing and the split point currently programmed
  int burst_left;
  int cur_split;

  tempo_row_rate_accumulator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  tempo_row_timer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .req_valid_i  (s_tvalid),
    .req_ready_i  (s_tready),
    .req_data_i   (s_tdata),
    .req_kind_i   (s_tuser),
    .row_valid_i  (m_tvalid),
    .row_ready_i  (m_tready),
    .row_data_i   (m_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result-side backpressure: long ready stretches, short and long stalls
  initial begin
    int hold_left;
    int pick;
    logic lvl;
    m_tready  = 1'b0;
    hold_left = 0;
    lvl       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0) begin
        pick = $urandom_range(9);
        if (pick < 4) begin
          lvl       = 1'b1;
          hold_left = $urandom_range(1, 40);
        end else if (pick < 8) begin
          lvl       = 1'b0;
          hold_left = $urandom_range(1, 3);
        end else begin
          lvl       = 1'b0;
          hold_left = $urandom_range(4, 24);
        end
      end
      hold_left--;
      m_tready <= lvl;
    end
  end

  // Send one request, hold it until accepted, then apply burst pacing
  task automatic issue(logic [FUNC_W-1:0] kind, logic [BYTE_W-1:0] param,
                       logic [BYTE_W-1:0] tempo, logic [BYTE_W-1:0] speed);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {speed, tempo, param};
    do @(posedge clk_i); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(9) < 2) burst_left = $urandom_range(40, 90);
      else burst_left = $urandom_range(0, 15);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending and wait until every predicted row has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Program both registers; block must be idle
  task automatic set_rates(logic [BYTE_W-1:0] frame_rate, logic [BYTE_W-1:0] split);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FRAME_RATE;
    cfg_wdata <= frame_rate;
    @(posedge clk_i);
    cfg_idx   <= CFG_SPLIT;
    cfg_wdata <= split;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    cur_split = int'(split);
  endtask

  function automatic logic [BYTE_W-1:0] pick_speed();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 55) return BYTE_W'($urandom_range(1, 8));
    return BYTE_W'($urandom_range(1, 255));
  endfunction

  // Mostly ticks between loads and effects, with some unused kinds as noise
  task automatic run_random(int count, bit mid_pause);
    int done_n;
    int r;
    int p;
    logic [BYTE_W-1:0] tempo;
    done_n = 0;
    while (done_n < count) begin
      r = $urandom_range(99);
      if (r < 62) begin
        issue(FUNC_TICK, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      end else if (r < 80) begin
        case ($urandom_range(5))
          0: p = cur_split - 1;
          1: p = cur_split;
          2: p = cur_split + 1;
          3: p = ($urandom_range(1) == 0) ? 0 : 255;
          default: p = $urandom_range(255);
        endcase
        if (p < 0) p = 0;
        if (p > 255) p = 255;
        issue(FUNC_EFFECT, BYTE_W'(p), BYTE_W'($urandom), BYTE_W'($urandom));
      end else if (r < 93) begin
        tempo = ($urandom_range(6) == 0) ? '0 : BYTE_W'($urandom_range(1, 255));
        issue(FUNC_LOAD, BYTE_W'($urandom), tempo, pick_speed());
      end else begin
        issue(FUNC_UNUSED, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      end
      if (s_tuser != FUNC_UNUSED) done_n++;
      // Let the pipeline empty once in the middle of the stream
      if (mid_pause && done_n == count / 2) begin
        mid_pause = 1'b0;
        drain();
      end
    end
  endtask

  initial begin
    cfg_we     = 1'b0;
    cfg_idx    = CFG_FRAME_RATE;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = FUNC_TICK;
    burst_left = 0;
    cur_split  = 32;
    rst_ni     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, effect split, zero speed, saturation, tempo-zero mode
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    issue(FUNC_TICK, 8'hff, 8'hff, 8'hff);
    issue(FUNC_EFFECT, 8'd0, 8'h00, 8'h00);
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    issue(FUNC_EFFECT, 8'd31, 8'h00, 8'h00);
    issue(FUNC_EFFECT, 8'd32, 8'h00, 8'h00);
    issue(FUNC_EFFECT, 8'd255, 8'hff, 8'hff);
    issue(FUNC_LOAD, 8'h00, 8'd255, 8'd1);
    repeat (5) issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    issue(FUNC_LOAD, 8'hff, 8'd0, 8'd0);
    issue(FUNC_EFFECT, 8'd200, 8'h00, 8'h00);
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    issue(FUNC_UNUSED, 8'hff, 8'hff, 8'hff);
    issue(FUNC_LOAD, 8'h00, 8'd1, 8'd255);
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    issue(FUNC_LOAD, 8'h00, 8'd255, 8'd255);
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    drain();

    // Highest frame rate drives the accumulator into positive saturation
    set_rates(8'd255, 8'd0);
    issue(FUNC_LOAD, 8'h00, 8'd1, 8'd255);
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    issue(FUNC_TICK, 8'h00, 8'h00, 8'h00);
    run_random(160, 1'b0);
    drain();

    // Zero frame rate: tempo refill is empty
    set_rates(8'd0, 8'd255);
    run_random(160, 1'b1);
    drain();

    set_rates(8'd1, 8'd128);
    run_random(160, 1'b0);
    drain();

    set_rates(BYTE_W'($urandom_range(1, 255)), BYTE_W'($urandom));
    run_random(150, 1'b0);
    drain();

    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ tempo_row_rate_accumulator_core.f @@
+incdir+rtl
rtl/trac_pkg.sv
rtl/trac_div.sv
rtl/tempo_row_rate_accumulator_core.sv
dv/tempo_row_timer_checker.sv
dv/tb_top.sv
